// ===== hw/rtl/kmeans_rgb_cluster_pass_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef KMEANS_RGB_CLUSTER_PASS_MACROS_SVH
`define KMEANS_RGB_CLUSTER_PASS_MACROS_SVH

// same-cycle implication, disabled during reset
`define KRC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("kmeans pass check failed");

// next-cycle implication, disabled during reset
`define KRC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("kmeans pass check failed");

`endif

// ===== hw/rtl/krc_pkg.sv =====
// shared types and constants of the k-means color pass engine
package krc_pkg;

    localparam int CH_W      = 8;
    localparam int SLOT_W    = 6;
    localparam int CLUSTER_W = 6;
    localparam int CFG_W     = 7;
    localparam int IDX_W     = 8;
    localparam int DIST_W    = 18;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic OP_SEED  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   red;
        logic              pass_end;
    } in_item_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic                 pass_done;
    } out_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } cen_t;

    // controller to datapath commands
    typedef struct packed {
        logic             seed_wr;
        logic             px_load;
        logic             srch_issue;
        logic             srch_first;
        logic             acc_rd;
        logic             acc_best;
        logic             acc_wr;
        logic             div_load;
        logic             div_step;
        logic             cen_wr_mean;
        logic             acc_clear;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } krc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic srch_busy;
        logic out_free;
    } krc_sts_t;

endpackage

// ===== hw/rtl/krc_ctrl.sv =====
// sequencing controller: search, accumulate, recompute and result hand-off
module krc_ctrl
    import krc_pkg::*;
#(
    parameter int MAX_CENTROIDS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_op,
    input  logic             in_pass_end,
    output logic             in_stall,
    output krc_cmd_t         cmd,
    input  krc_sts_t         sts
);

    localparam int IW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam logic [2:0] DIV_LAST = 3'(CH_W - 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SEARCH  = 4'd1;
    localparam logic [3:0] ST_DRAIN   = 4'd2;
    localparam logic [3:0] ST_ACC_RD  = 4'd3;
    localparam logic [3:0] ST_ACC_WR  = 4'd4;
    localparam logic [3:0] ST_RC_RD   = 4'd5;
    localparam logic [3:0] ST_RC_LOAD = 4'd6;
    localparam logic [3:0] ST_RC_DIV  = 4'd7;
    localparam logic [3:0] ST_RC_WR   = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [2:0]       step_reg, step_next;
    logic             pend_reg, pend_next;
    logic [CFG_W-1:0] active_reg;
    logic [IW-1:0]    k_last;
    logic             accept;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    // last searched slot, register clamped to 1..MAX_CENTROIDS
    always_comb
    begin
        int kv;
        kv = int'(active_reg);
        if (kv == 0)
        begin
            kv = 1;
        end
        if (kv > MAX_CENTROIDS)
        begin
            kv = MAX_CENTROIDS;
        end
        k_last = IW'(kv - 1);
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // state machine
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.idx    = IDX_W'(idx_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_SEED)
                    begin
                        cmd.seed_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.px_load = 1'b1;
                        pend_next   = in_pass_end;
                        idx_next    = '0;
                        state_next  = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.srch_issue = 1'b1;
                cmd.srch_first = (idx_reg == '0);
                if (idx_reg == k_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.srch_busy)
                begin
                    state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD:
            begin
                cmd.acc_rd   = 1'b1;
                cmd.acc_best = 1'b1;
                state_next   = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                idx_next   = '0;
                state_next = pend_reg ? ST_RC_RD : ST_FIN;
            end
            ST_RC_RD:
            begin
                cmd.acc_rd = 1'b1;
                state_next = ST_RC_LOAD;
            end
            ST_RC_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_RC_DIV;
            end
            ST_RC_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_RC_WR;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_RC_WR:
            begin
                cmd.cen_wr_mean = 1'b1;
                if (idx_reg == k_last)
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RC_RD;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== hw/rtl/krc_datapath.sv =====
// centroid and accumulator memories, distance pipeline, divider and result register
module krc_datapath
    import krc_pkg::*;
#(
    parameter int MAX_CENTROIDS = 64,
    parameter int MAX_PIXELS    = 1048576
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  krc_cmd_t  cmd,
    output krc_sts_t  sts,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int IW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + CH_W;
    localparam int AW = 3 * SW + CW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PIXELS);

    // memories
    cen_t              cen_mem [MAX_CENTROIDS];
    logic [AW-1:0]     acc_mem [MAX_CENTROIDS];
    logic [MAX_CENTROIDS-1:0] cen_vld_reg;
    logic [MAX_CENTROIDS-1:0] acc_vld_reg;

    // pixel under work
    logic [CH_W-1:0]   px_reg [3];
    logic              pend_reg;

    // search pipeline
    cen_t              cen_rd_reg;
    logic              cen_rv_reg;
    logic              s1_v_reg, s1_first_reg;
    logic [IW-1:0]     s1_idx_reg;
    logic [2*CH_W-1:0] sq_reg [3];
    logic              s2_v_reg, s2_first_reg;
    logic [IW-1:0]     s2_idx_reg;
    logic [IW-1:0]     best_reg;
    logic [DIST_W-1:0] best_d_reg;

    // accumulator read and divider
    logic [AW-1:0]     acc_rd_reg;
    logic              acc_rv_reg;
    logic [SW-1:0]     rem_reg [3];
    logic [CW-1:0]     dvn_reg;
    logic [2:0]        sh_reg;
    logic [CH_W-1:0]   q_reg [3];

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [IW-1:0]     cmd_addr;
    logic [IW-1:0]     acc_addr;
    logic [IW-1:0]     seed_addr;
    logic              seed_ok;
    logic [CH_W-1:0]   cen_ch [3];
    logic [DIST_W-1:0] dist_sum;
    logic [AW-1:0]     acc_eff;
    logic [CW-1:0]     acc_cnt;
    logic [AW-1:0]     acc_new;
    logic [SW-1:0]     trial;
    cen_t              mean;

    assign cmd_addr  = IW'(cmd.idx);
    assign acc_addr  = cmd.acc_best ? best_reg : cmd_addr;
    assign seed_addr = IW'(in_data.slot);
    assign seed_ok   = (int'(in_data.slot) < MAX_CENTROIDS);

    // effective read data, unwritten rows read as zero
    assign cen_ch[0] = cen_rv_reg ? cen_rd_reg.blue  : '0;
    assign cen_ch[1] = cen_rv_reg ? cen_rd_reg.green : '0;
    assign cen_ch[2] = cen_rv_reg ? cen_rd_reg.red   : '0;
    assign acc_eff   = acc_rv_reg ? acc_rd_reg : '0;
    assign acc_cnt   = acc_eff[CW-1:0];
    assign dist_sum  = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);

    // accumulator update for the winning cluster
    always_comb
    begin
        acc_new[CW-1:0] = acc_cnt + 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            acc_new[CW + c*SW +: SW] = acc_eff[CW + c*SW +: SW] + SW'(px_reg[c]);
        end
    end

    assign trial = SW'(dvn_reg) << sh_reg;
    assign mean.blue  = (dvn_reg == '0) ? '0 : q_reg[0];
    assign mean.green = (dvn_reg == '0) ? '0 : q_reg[1];
    assign mean.red   = (dvn_reg == '0) ? '0 : q_reg[2];

    // centroid memory
    always_ff @(posedge clk)
    begin
        if (cmd.seed_wr && seed_ok)
        begin
            cen_mem[seed_addr] <= '{red: in_data.red, green: in_data.green,
                                    blue: in_data.blue};
        end
        else if (cmd.cen_wr_mean)
        begin
            cen_mem[cmd_addr] <= mean;
        end
        cen_rd_reg <= cen_mem[cmd_addr];
    end

    // accumulator memory
    always_ff @(posedge clk)
    begin
        if (cmd.acc_wr && (acc_cnt < CNT_MAX))
        begin
            acc_mem[best_reg] <= acc_new;
        end
        if (cmd.acc_rd)
        begin
            acc_rd_reg <= acc_mem[acc_addr];
        end
    end

    // valid bits and read tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_vld_reg <= '0;
            acc_vld_reg <= '0;
            cen_rv_reg  <= 1'b0;
            acc_rv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.seed_wr && seed_ok)
            begin
                cen_vld_reg[seed_addr] <= 1'b1;
            end
            else if (cmd.cen_wr_mean)
            begin
                cen_vld_reg[cmd_addr] <= 1'b1;
            end
            if (cmd.acc_clear)
            begin
                acc_vld_reg <= '0;
            end
            else if (cmd.acc_wr && (acc_cnt < CNT_MAX))
            begin
                acc_vld_reg[best_reg] <= 1'b1;
            end
            cen_rv_reg <= cen_vld_reg[cmd_addr];
            if (cmd.acc_rd)
            begin
                acc_rv_reg <= acc_vld_reg[acc_addr];
            end
        end
    end

    // pixel capture
    always_ff @(posedge clk)
    begin
        if (cmd.px_load)
        begin
            px_reg[0] <= in_data.blue;
            px_reg[1] <= in_data.green;
            px_reg[2] <= in_data.red;
            pend_reg  <= in_data.pass_end;
        end
    end

    // search pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.srch_issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    // squared channel distances, then sum and compare
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= cmd_addr;
        s1_first_reg <= cmd.srch_first;
        s2_idx_reg   <= s1_idx_reg;
        s2_first_reg <= s1_first_reg;
        for (int c = 0; c < 3; c++)
        begin
            if (cen_ch[c] > px_reg[c])
            begin
                sq_reg[c] <= (cen_ch[c] - px_reg[c]) * (cen_ch[c] - px_reg[c]);
            end
            else
            begin
                sq_reg[c] <= (px_reg[c] - cen_ch[c]) * (px_reg[c] - cen_ch[c]);
            end
        end
        if (s2_v_reg && (s2_first_reg || (dist_sum < best_d_reg)))
        begin
            best_d_reg <= dist_sum;
            best_reg   <= s2_idx_reg;
        end
    end

    // restoring divider, one quotient bit per step for all three channels
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvn_reg <= acc_cnt;
            sh_reg  <= 3'(CH_W - 1);
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= acc_eff[CW + c*SW +: SW];
            end
        end
        else if (cmd.div_step)
        begin
            sh_reg <= sh_reg - 1'b1;
            for (int c = 0; c < 3; c++)
            begin
                if (rem_reg[c] >= trial)
                begin
                    rem_reg[c] <= rem_reg[c] - trial;
                    q_reg[c]   <= {q_reg[c][CH_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[c] <= {q_reg[c][CH_W-2:0], 1'b0};
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.cluster   <= CLUSTER_W'(best_reg);
            out_data_reg.pass_done <= pend_reg;
        end
    end

    assign sts.srch_busy = s1_v_reg || s2_v_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

// ===== hw/rtl/kmeans_rgb_cluster_pass.sv =====
// top level of the k-means color pass engine
// seed transaction: no result; pixel: a search over all K slots, K = active centroids,
// by the shared distance unit visiting one centroid slot per cycle
// pixel ending a pass: plus a mean recompute per active centroid by the 8-step mean divider
// one transaction in flight; the result register lets the next one enter while it waits
// reset (rst_n low, asynchronous) clears control state, valid bits and sets K to 64
module kmeans_rgb_cluster_pass
    import krc_pkg::*;
#(
    parameter int MAX_CENTROIDS = 64,
    parameter int MAX_PIXELS    = 1048576
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    krc_cmd_t cmd;
    krc_sts_t sts;

    // controller
    krc_ctrl #(
        .MAX_CENTROIDS (MAX_CENTROIDS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_op       (in_data.op),
        .in_pass_end (in_data.pass_end),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    // datapath
    krc_datapath #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_PIXELS    (MAX_PIXELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/krc_checker.sv =====
// port-level checks of the k-means color pass engine and their binding
`include "kmeans_rgb_cluster_pass_macros.svh"

module krc_checker
    import krc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a stalled result stays
    `KRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `KRC_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

    // a seed transaction never brings out a result
    `KRC_ASSERT_NXT(a_seed_silent, clk, rst_n, in_valid && !in_stall && (in_data.op == OP_SEED), !$rose(out_valid))

    // a pixel occupies the engine for at least the next cycle
    `KRC_ASSERT_NXT(a_pixel_busy, clk, rst_n, in_valid && !in_stall && (in_data.op == OP_PIXEL), in_stall)

endmodule

bind kmeans_rgb_cluster_pass krc_checker u_krc_checker (.*);
